/* design/wsdf_pkg.sv */
// Shared types for the WebSocket frame deframer: parse phase codes and
// the result word. No dependencies.
`default_nettype none

package wsdf_pkg;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES = 4'd4;
    localparam logic [3:0] OPC_CONT = 4'h0;

    typedef enum logic [4:0] {
        PH_HDR0   = 5'b00001,
        PH_HDR1   = 5'b00010,
        PH_EXTLEN = 5'b00100,
        PH_KEY    = 5'b01000,
        PH_DATA   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       message_final;
        logic       frame_last;
        logic       empty_frame;
    } t_word;

    typedef struct packed {
        logic  valid;
        t_word word;
    } t_result;

endpackage

`default_nettype wire

/* design/wsdf_parser.sv */
// Frame header parser and payload unmasker: holds all per-frame state.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    output wsdf_pkg::t_result      o_res
);
    import wsdf_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_op, n_op;
    logic        r_mask, n_mask;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_pos, n_pos;
    logic [3:0]  r_frag, n_frag;

    logic        after_len;
    logic        finish;
    logic [6:0]  len7;
    logic [7:0]  kb;

    always_comb begin
        n_phase = r_phase;
        n_fin   = r_fin;
        n_op    = r_op;
        n_mask  = r_mask;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_key   = r_key;
        n_pos   = r_pos;
        n_frag  = r_frag;
        after_len = 1'b0;
        finish    = 1'b0;
        len7      = i_byte[6:0];
        kb        = 8'd0;
        o_res     = '0;

        unique case (r_phase)
            PH_HDR0: begin
                n_fin   = i_byte[7];
                n_op    = i_byte[3:0];
                n_phase = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask = i_byte[7];
                if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
                    n_cnt   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_rem   = 64'd0;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_rem     = {57'd0, len7};
                    after_len = 1'b1;
                end
            end
            PH_EXTLEN: begin
                // extended length arrives most significant byte first
                n_rem = {r_rem[55:0], i_byte};
                n_cnt = r_cnt - 4'd1;
                after_len = (n_cnt == 4'd0);
            end
            PH_KEY: begin
                n_key  = {r_key[23:0], i_byte};
                n_cnt  = r_cnt - 4'd1;
                finish = (n_cnt == 4'd0);
            end
            PH_DATA: begin
                unique case (r_pos)
                    2'd0: kb = r_key[31:24];
                    2'd1: kb = r_key[23:16];
                    2'd2: kb = r_key[15:8];
                    default: kb = r_key[7:0];
                endcase
                n_pos = r_pos + 2'd1;
                n_rem = r_rem - 64'd1;
                o_res.valid = 1'b1;
                o_res.word.payload_byte  = r_mask ? (i_byte ^ kb) : i_byte;
                o_res.word.frame_opcode  = r_op;
                o_res.word.message_final = r_fin;
                o_res.word.frame_last    = (n_rem == 64'd0);
                if (n_rem == 64'd0) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase

        if (after_len) begin
            if (n_mask) begin
                n_cnt   = KEY_BYTES;
                n_key   = 32'd0;
                n_phase = PH_KEY;
            end else begin
                finish = 1'b1;
            end
        end

        if (finish) begin
            // resolve the effective opcode of the frame
            if (n_fin) begin
                if (n_op == OPC_CONT) begin
                    n_op   = r_frag;
                    n_frag = OPC_CONT;
                end
            end else if (n_op != OPC_CONT) begin
                n_frag = n_op;
            end
            n_pos = 2'd0;
            if (n_rem == 64'd0) begin
                n_phase = PH_HDR0;
                o_res.valid = 1'b1;
                o_res.word.payload_byte  = 8'd0;
                o_res.word.frame_opcode  = n_op;
                o_res.word.message_final = n_fin;
                o_res.word.frame_last    = 1'b1;
                o_res.word.empty_frame   = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_fin   <= 1'b0;
            r_op    <= 4'd0;
            r_mask  <= 1'b0;
            r_cnt   <= 4'd0;
            r_rem   <= 64'd0;
            r_key   <= 32'd0;
            r_pos   <= 2'd0;
            r_frag  <= 4'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_fin   <= n_fin;
            r_op    <= n_op;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_pos   <= n_pos;
            r_frag  <= n_frag;
        end
    end

endmodule

`default_nettype wire

/* design/websocket_frame_deframer_core.sv */
// Top level of the WebSocket frame deframer: input register, parser and
// output register. Depends on wsdf_pkg and wsdf_parser.
//
// Usage:
//   Input channel: one stream byte per word on i_rx_byte, qualified by
//   i_valid; the block holds it off with o_stall. A word is taken at a
//   rising edge with i_valid high and o_stall low.
//   Output channel: one result word (unmasked payload byte, effective
//   opcode, fin, frame_last, empty_frame) qualified by o_valid; the
//   receiver holds it off with i_stall.
//   Header bytes give no result, except the empty-frame marker on the last
//   header byte of a zero-length frame. Every payload byte gives one.
//   Path: a byte is held in the input register, and its parser result in
//   the output register. Throughput: one byte per cycle while i_stall is
//   low, with the 64-bit length countdown and compare done in each step.
//   Stall: when the output word is held by i_stall, the parser stops; a
//   byte already in the input register waits there, and o_stall rises
//   only while that register is full. With the input register empty a new
//   byte is still taken while a result waits.
//   Reset (synchronous, active low): parser returns to the first header
//   byte with all frame state cleared; both registers are emptied.
`default_nettype none

module websocket_frame_deframer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_payload_byte,
    output logic [3:0]      o_frame_opcode,
    output logic            o_message_final,
    output logic            o_frame_last,
    output logic            o_empty_frame
);
    import wsdf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_word      r_out_word;

    logic       advance;
    logic       step;
    t_result    res;

    // pipeline moves whenever the output register can take a word
    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    wsdf_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step && res.valid) begin
            r_out_word <= res.word;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_out_word.payload_byte;
    assign o_frame_opcode  = r_out_word.frame_opcode;
    assign o_message_final = r_out_word.message_final;
    assign o_frame_last    = r_out_word.frame_last;
    assign o_empty_frame   = r_out_word.empty_frame;

endmodule

`default_nettype wire
